/* rtl/core/s2lab_pkg.sv */
// ----------------------------------------------------------------------------
// s2lab_pkg
// Shared constants, types and the sRGB linearisation table for the
// sRGB to CIELAB (D65) converter.
// ----------------------------------------------------------------------------
package s2lab_pkg;

    localparam int WORK_BITS     = 24;
    localparam int FRAC_BITS_DEF = 8;
    localparam int LIN_W         = WORK_BITS + 1;
    localparam int COEF_W        = 16;
    localparam int PROD_W        = COEF_W + LIN_W;
    localparam int L_W           = 15;
    localparam int AB_W          = 16;
    localparam int PIX_W         = 32;
    localparam int OUT_TDATA_W   = 48;
    localparam int ROOT_STEPS    = WORK_BITS;
    localparam int DIV_STEPS     = 23;
    localparam int REM_W         = 34;
    localparam int LAB_W         = 36;

    localparam longint unsigned UNIT      = 64'd1 << WORK_BITS;
    localparam longint unsigned KAPPA_NUM = 64'd24389;
    localparam longint unsigned EPS_NUM   = 64'd216;
    localparam longint unsigned DIV_CONST = 64'd3132;
    localparam longint unsigned LIN_BIAS  = 64'd432 * UNIT + 64'd1566;

    typedef logic [COEF_W-1:0] t_coef_row [3];
    typedef t_coef_row         t_coef_mat [3];

    // sRGB to XYZ, divided by the D65 white point, Q0.16
    localparam t_coef_mat XYZ_MAT = '{
        '{16'd28431, 16'd24658, 16'd12447},
        '{16'd13933, 16'd46871, 16'd4732},
        '{16'd1163,  16'd7172,  16'd57201}
    };

    typedef logic [LIN_W-1:0] t_lin_tab [256];

    // Per-channel state carried through the cube root and divider steps
    typedef struct packed {
        logic [LIN_W-1:0]     t;
        logic                 cube_sel;
        logic                 at_one;
        logic [WORK_BITS-1:0] root;
        logic [REM_W-1:0]     rem;
        logic [DIV_STEPS-1:0] quo;
    } t_chan;

    function automatic longint unsigned qmul(longint unsigned a, longint unsigned b);
        return (a * b + (UNIT >> 1)) >> WORK_BITS;
    endfunction

    function automatic longint unsigned lin_entry(longint unsigned c);
        longint unsigned s, lo, hi, mid, r2, p5;
        if (c <= 64'd10)
            return (c * 64'd100 * UNIT + 64'd164730) / 64'd329460;
        s = ((c * 64'd1000 + 64'd14025) * UNIT + 64'd134512) / 64'd269025;
        if (s > UNIT)
            s = UNIT;
        lo = 0;
        hi = UNIT;
        for (int i = 0; i < 40; i++) begin
            if (lo < hi) begin
                mid = (lo + hi + 64'd1) >> 1;
                r2  = qmul(mid, mid);
                p5  = qmul(qmul(r2, r2), mid);
                if (p5 <= s)
                    lo = mid;
                else
                    hi = mid - 64'd1;
            end
        end
        return qmul(qmul(s, s), qmul(lo, lo));
    endfunction

    function automatic t_lin_tab build_lin_tab();
        t_lin_tab tab;
        for (int c = 0; c < 256; c++)
            tab[c] = LIN_W'(lin_entry(longint'(c)));
        return tab;
    endfunction

    localparam t_lin_tab LIN_TAB = build_lin_tab();

endpackage

/* rtl/core/srgb_to_cielab_pixel_top.sv */
// ----------------------------------------------------------------------------
// srgb_to_cielab_pixel_top
// Streaming sRGB (ARGB pixel) to CIELAB D65 converter, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel takes one ARGB pixel per beat (alpha ignored). Master
//   channel gives one Lab result per beat: L* unsigned, a* and b* signed,
//   each with FRAC_BITS fraction bits, saturated to the field widths.
//   Throughput is one pixel per clock, sustained while the receiver
//   accepts beats; the 24-step cube root, two register stages per step
//   (square, then cube and compare), sets the depth.
//   Pipeline: table lookup, matrix products, matrix sums, setup, 48 root
//   stages (linear-segment divider runs alongside), Lab products, rounding
//   and clamp into the output register.
//   Reset empties the pipeline; o_s_tready is high straight after reset.
//   When the receiver stalls with a beat waiting, the whole pipeline holds
//   and o_s_tready drops in the same cycle; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module srgb_to_cielab_pixel_top
    import s2lab_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [PIX_W-1:0]       i_s_tdata,   // pixel[31:0]
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata    // lightness[14:0], green_red[30:15],
                                                // blue_yellow[46:31], zero[47]
);

    localparam int LAT   = 4 + 2 * ROOT_STEPS + 2;
    localparam int SH    = WORK_BITS - FRAC_BITS;
    localparam longint L_RAW_MAX = longint'(100) << FRAC_BITS;
    localparam longint L_LIM = (L_RAW_MAX > 32767) ? 32767 : L_RAW_MAX;
    localparam logic [LAB_W:0] HALF = (LAB_W+1)'(1) << (SH - 1);

    logic                   en;
    logic [LAT-1:0]         r_vld;
    logic [LIN_W-1:0]       r_lin  [3];
    logic [PROD_W-1:0]      r_prod [3][3];
    logic [LIN_W-1:0]       r_t    [3];
    t_chan                  r_b    [3][ROOT_STEPS+1];
    t_chan                  r_a    [3][ROOT_STEPS];
    logic [WORK_BITS-1:0]   r_sq   [3][ROOT_STEPS];
    logic [WORK_BITS-1:0]   r_ca   [3][ROOT_STEPS];
    logic [LIN_W-1:0]       f      [3];
    logic signed [LAB_W-1:0] r_lq, r_aq, r_bq;
    logic [L_W-1:0]         r_l, n_l;
    logic [AB_W-1:0]        r_ga, n_ga, r_by, n_by;

    // Advance everything unless a finished beat is held at the output
    assign en         = !r_vld[LAT-1] || i_m_tready;
    assign o_s_tready = en;
    assign o_m_tvalid = r_vld[LAT-1];
    assign o_m_tdata  = {1'b0, r_by, r_ga, r_l};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_s_tvalid};
        end
    end

    genvar ch, col, j;
    generate
        for (ch = 0; ch < 3; ch++) begin : g_ch
            logic [LIN_W+COEF_W+1:0] sum;
            logic [39:0]             keps;

            assign sum = {2'b00, r_prod[ch][0]} + {2'b00, r_prod[ch][1]}
                       + {2'b00, r_prod[ch][2]} + (LIN_W+COEF_W+2)'(32768);
            assign keps = 40'(r_t[ch]) * 40'(KAPPA_NUM);

            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_lin[ch] <= LIN_TAB[i_s_tdata[8*(2-ch) +: 8]];
                    r_t[ch]   <= sum[LIN_W+15:16];
                    r_b[ch][0].t        <= r_t[ch];
                    r_b[ch][0].cube_sel <= keps > 40'(EPS_NUM * UNIT);
                    r_b[ch][0].at_one   <= r_t[ch][WORK_BITS];
                    r_b[ch][0].root     <= '0;
                    r_b[ch][0].rem      <= REM_W'(64'(r_t[ch][17:0]) * KAPPA_NUM + LIN_BIAS);
                    r_b[ch][0].quo      <= '0;
                end
            end

            for (col = 0; col < 3; col++) begin : g_col
                always_ff @(posedge i_clk) begin
                    if (en) begin
                        r_prod[ch][col] <= PROD_W'(XYZ_MAT[ch][col]) * PROD_W'(r_lin[col]);
                    end
                end
            end

            for (j = 0; j < ROOT_STEPS; j++) begin : g_step
                logic [WORK_BITS-1:0]   cand;
                logic [2*WORK_BITS-1:0] sqp, cbp;
                logic [WORK_BITS-1:0]   cube;
                t_chan                  nxt;

                assign cand = r_b[ch][j].root | (WORK_BITS'(1) << (WORK_BITS - 1 - j));
                assign sqp  = cand * cand + (2*WORK_BITS)'(UNIT >> 1);
                assign cbp  = r_sq[ch][j] * r_ca[ch][j] + (2*WORK_BITS)'(UNIT >> 1);
                assign cube = cbp[2*WORK_BITS-1:WORK_BITS];

                if (j < DIV_STEPS) begin : g_div
                    localparam int K = DIV_STEPS - 1 - j;
                    localparam logic [REM_W-1:0] DSH = REM_W'(DIV_CONST << K);
                    always_comb begin
                        nxt      = r_a[ch][j];
                        nxt.root = ({1'b0, cube} <= r_a[ch][j].t) ? r_ca[ch][j]
                                                                  : r_a[ch][j].root;
                        if (r_a[ch][j].rem >= DSH) begin
                            nxt.rem    = r_a[ch][j].rem - DSH;
                            nxt.quo[K] = 1'b1;
                        end
                    end
                end else begin : g_nodiv
                    always_comb begin
                        nxt      = r_a[ch][j];
                        nxt.root = ({1'b0, cube} <= r_a[ch][j].t) ? r_ca[ch][j]
                                                                  : r_a[ch][j].root;
                    end
                end

                always_ff @(posedge i_clk) begin
                    if (en) begin
                        r_a[ch][j]    <= r_b[ch][j];
                        r_ca[ch][j]   <= cand;
                        r_sq[ch][j]   <= sqp[2*WORK_BITS-1:WORK_BITS];
                        r_b[ch][j+1]  <= nxt;
                    end
                end
            end

            // Pick the cube root, the linear segment, or exactly one
            always_comb begin
                priority if (r_b[ch][ROOT_STEPS].at_one)
                    f[ch] = LIN_W'(UNIT);
                else if (r_b[ch][ROOT_STEPS].cube_sel)
                    f[ch] = {1'b0, r_b[ch][ROOT_STEPS].root};
                else
                    f[ch] = LIN_W'(r_b[ch][ROOT_STEPS].quo);
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_lq <= LAB_W'(116) * $signed({11'b0, f[1]}) - LAB_W'(16 * UNIT);
            r_aq <= LAB_W'(500) * ($signed({11'b0, f[0]}) - $signed({11'b0, f[1]}));
            r_bq <= LAB_W'(200) * ($signed({11'b0, f[1]}) - $signed({11'b0, f[2]}));
            r_l  <= n_l;
            r_ga <= n_ga;
            r_by <= n_by;
        end
    end

    function automatic logic signed [LAB_W:0] round_q(logic signed [LAB_W-1:0] v);
        logic [LAB_W:0] mag;
        logic [LAB_W:0] rm;
        mag = v[LAB_W-1] ? (LAB_W+1)'(-{v[LAB_W-1], v}) : (LAB_W+1)'({1'b0, v});
        rm  = (mag + HALF) >> SH;
        return v[LAB_W-1] ? -$signed(rm) : $signed(rm);
    endfunction

    logic signed [LAB_W:0] lr, ar, br;

    always_comb begin
        lr = round_q(r_lq);
        ar = round_q(r_aq);
        br = round_q(r_bq);
        priority if (lr < 0)              n_l = '0;
        else if (lr > (LAB_W+1)'(32767))  n_l = L_W'(32767);
        else                              n_l = lr[L_W-1:0];
        priority if (ar < -(LAB_W+1)'(32768)) n_ga = 16'h8000;
        else if (ar > (LAB_W+1)'(32767))      n_ga = 16'h7FFF;
        else                                  n_ga = ar[AB_W-1:0];
        priority if (br < -(LAB_W+1)'(32768)) n_by = 16'h8000;
        else if (br > (LAB_W+1)'(32767))      n_by = 16'h7FFF;
        else                                  n_by = br[AB_W-1:0];
    end

`ifndef NO_ASSERTIONS
    a_rst_empty : assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("pipeline not empty after reset");

    a_stall_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> $stable(r_vld))
        else $error("pipeline moved during stall");

    a_l_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (longint'(o_m_tdata[L_W-1:0]) <= L_LIM))
        else $error("lightness beyond 100");
`endif

endmodule
